FILE: sv/chs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

    localparam int KEY_W       = 64;
    localparam int PTR_W       = 64;
    localparam int INT_W       = 32;
    localparam int CMD_W       = 2;
    localparam int CFG_W       = 9;
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_USED_W  = 1 + PTR_W + INT_W + 1;
    localparam int MOD_BITS    = 8;
    localparam int MOD_CYCLES  = KEY_W / MOD_BITS;
    localparam int MCNT_W      = $clog2(MOD_CYCLES);

    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_PTR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_INT = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HEAD,
        S_CMP,
        S_UPD
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic head_rd;
        logic head_take;
        logic ent_next;
        logic hit_take;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic head_zero;
        logic hit;
        logic link_zero;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: sv/chs_mod.sv
`timescale 1ns / 1ps
`default_nettype none

module chs_mod #(
    parameter int DIV_W = 9
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [chs_pkg::KEY_W-1:0]       i_key,
    input  wire logic [DIV_W-1:0]                i_div,
    output logic                                 o_done,
    output logic [DIV_W-1:0]                     o_rem
);

    logic [chs_pkg::KEY_W-1:0]  r_kx;
    logic [DIV_W-1:0]           r_rem;
    logic [DIV_W-1:0]           n_rem;
    logic [chs_pkg::MCNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    always_comb begin
        logic [DIV_W:0] t;
        t     = '0;
        n_rem = r_rem;
        for (int i = 0; i < chs_pkg::MOD_BITS; i++) begin
            t = {n_rem, r_kx[chs_pkg::KEY_W-1-i]};
            if (t >= {1'b0, i_div}) begin
                t = t - {1'b0, i_div};
            end
            n_rem = t[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == chs_pkg::MCNT_W'(chs_pkg::MOD_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kx  <= i_key;
            r_rem <= '0;
        end else if (r_busy) begin
            r_kx  <= r_kx << chs_pkg::MOD_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef NO_ASSERTIONS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < i_div))
        else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: sv/chs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module chs_datapath #(
    parameter int MAX_BUCKETS  = 256,
    parameter int POOL_ENTRIES = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire chs_pkg::t_dp_cmd                 i_cmd,
    output chs_pkg::t_dp_sts                      o_sts,
    input  wire logic                             i_cfg_valid,
    input  wire logic [chs_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic [chs_pkg::CMD_W-1:0]        i_req_cmd,
    input  wire logic [chs_pkg::KEY_W-1:0]        i_req_key,
    input  wire logic [chs_pkg::PTR_W-1:0]        i_req_ptr,
    input  wire logic [chs_pkg::INT_W-1:0]        i_req_int,
    output logic                                  o_res_valid,
    input  wire logic                             i_res_ready,
    output logic                                  o_res_found,
    output logic [chs_pkg::PTR_W-1:0]             o_res_ptr,
    output logic [chs_pkg::INT_W-1:0]             o_res_int,
    output logic                                  o_res_status
);

    localparam int DIV_W  = $clog2(MAX_BUCKETS + 1);
    localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int IDX_W  = $clog2(POOL_ENTRIES);
    localparam int LINK_W = $clog2(POOL_ENTRIES + 1);

    logic [DIV_W-1:0]           r_div;
    logic [chs_pkg::CMD_W-1:0]  r_cmd;
    logic [chs_pkg::KEY_W-1:0]  r_key;
    logic [chs_pkg::PTR_W-1:0]  r_ptr;
    logic [chs_pkg::INT_W-1:0]  r_int;
    logic                       r_found;

    logic                       w_mod_done;
    logic [DIV_W-1:0]           w_rem;
    logic [BKT_W-1:0]           w_bkt;

    logic [LINK_W-1:0]          r_heads [MAX_BUCKETS];
    logic [LINK_W-1:0]          r_head_q;
    logic [BKT_W-1:0]           r_bucket;
    logic [BKT_W-1:0]           r_clr;

    logic [chs_pkg::KEY_W-1:0]  r_keys  [POOL_ENTRIES];
    logic [chs_pkg::PTR_W-1:0]  r_ptrs  [POOL_ENTRIES];
    logic [chs_pkg::INT_W-1:0]  r_ints  [POOL_ENTRIES];
    logic [LINK_W-1:0]          r_links [POOL_ENTRIES];
    logic [chs_pkg::KEY_W-1:0]  r_key_q;
    logic [chs_pkg::PTR_W-1:0]  r_ptr_q;
    logic [chs_pkg::INT_W-1:0]  r_int_q;
    logic [LINK_W-1:0]          r_lnk_q;
    logic [LINK_W-1:0]          r_link;
    logic [LINK_W-1:0]          r_used;

    logic                       w_rd_en;
    logic [LINK_W-1:0]          w_rd_link;
    logic [LINK_W-1:0]          w_rd_dec;
    logic [IDX_W-1:0]           w_rd_idx;
    logic [LINK_W-1:0]          w_cur_dec;
    logic [IDX_W-1:0]           w_wr_idx;
    logic                       w_is_set;
    logic                       w_full;
    logic                       w_new_ok;
    logic                       w_new_wr;
    logic                       w_upd_wr;
    logic [chs_pkg::PTR_W-1:0]  w_ptr_wd;
    logic [chs_pkg::INT_W-1:0]  w_int_wd;
    logic                       w_out_free;

    logic                       r_out_valid;
    logic                       r_out_found;
    logic [chs_pkg::PTR_W-1:0]  r_out_ptr;
    logic [chs_pkg::INT_W-1:0]  r_out_int;
    logic                       r_out_status;
    logic [chs_pkg::PTR_W-1:0]  n_out_ptr;
    logic [chs_pkg::INT_W-1:0]  n_out_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= DIV_W'(MAX_BUCKETS);
        end else if (i_cfg_valid) begin
            if (i_cfg_data == '0) begin
                r_div <= DIV_W'(1);
            end else if (32'(i_cfg_data) > 32'(MAX_BUCKETS)) begin
                r_div <= DIV_W'(MAX_BUCKETS);
            end else begin
                r_div <= DIV_W'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_req_cmd;
            r_key <= i_req_key;
            r_ptr <= i_req_ptr;
            r_int <= i_req_int;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_found <= 1'b0;
        end else if (i_cmd.hit_take) begin
            r_found <= 1'b1;
        end
    end

    chs_mod #(
        .DIV_W (DIV_W)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load),
        .i_key   (i_req_key),
        .i_div   (r_div),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    assign w_bkt = w_rem[BKT_W-1:0];

    assign w_is_set = (r_cmd == chs_pkg::CMD_SET_PTR) || (r_cmd == chs_pkg::CMD_SET_INT);
    assign w_full   = (r_used == LINK_W'(POOL_ENTRIES));
    assign w_new_ok = w_is_set && !r_found && !w_full;
    assign w_new_wr = i_cmd.commit && w_new_ok;
    assign w_upd_wr = i_cmd.commit && w_is_set && r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_heads[r_clr] <= '0;
        end else if (w_new_wr) begin
            r_heads[r_bucket] <= r_used + LINK_W'(1);
        end
        if (i_cmd.head_rd) begin
            r_head_q <= r_heads[w_bkt];
            r_bucket <= w_bkt;
        end
    end

    assign w_rd_en   = i_cmd.head_take || i_cmd.ent_next;
    assign w_rd_link = i_cmd.head_take ? r_head_q : r_lnk_q;
    assign w_rd_dec  = w_rd_link - LINK_W'(1);
    assign w_rd_idx  = w_rd_dec[IDX_W-1:0];
    assign w_cur_dec = r_link - LINK_W'(1);
    assign w_wr_idx  = r_found ? w_cur_dec[IDX_W-1:0] : r_used[IDX_W-1:0];
    assign w_ptr_wd  = (r_cmd == chs_pkg::CMD_SET_PTR) ? r_ptr : '0;
    assign w_int_wd  = (r_cmd == chs_pkg::CMD_SET_INT) ? r_int : '0;

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_link  <= w_rd_link;
            r_key_q <= r_keys[w_rd_idx];
            r_ptr_q <= r_ptrs[w_rd_idx];
            r_int_q <= r_ints[w_rd_idx];
            r_lnk_q <= r_links[w_rd_idx];
        end
        if (w_new_wr) begin
            r_keys[w_wr_idx]  <= r_key;
            r_links[w_wr_idx] <= r_head_q;
        end
        if (w_new_wr || (w_upd_wr && (r_cmd == chs_pkg::CMD_SET_PTR))) begin
            r_ptrs[w_wr_idx] <= w_ptr_wd;
        end
        if (w_new_wr || (w_upd_wr && (r_cmd == chs_pkg::CMD_SET_INT))) begin
            r_ints[w_wr_idx] <= w_int_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (w_new_wr) begin
            r_used <= r_used + LINK_W'(1);
        end
    end

    always_comb begin
        if (r_found) begin
            n_out_ptr = (r_cmd == chs_pkg::CMD_SET_PTR) ? r_ptr : r_ptr_q;
            n_out_int = (r_cmd == chs_pkg::CMD_SET_INT) ? r_int : r_int_q;
        end else if (w_new_ok) begin
            n_out_ptr = w_ptr_wd;
            n_out_int = w_int_wd;
        end else begin
            n_out_ptr = '0;
            n_out_int = '0;
        end
    end

    assign w_out_free = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_found  <= r_found;
            r_out_ptr    <= n_out_ptr;
            r_out_int    <= n_out_int;
            r_out_status <= w_is_set && !r_found && w_full;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_res_found  = r_out_found;
    assign o_res_ptr    = r_out_ptr;
    assign o_res_int    = r_out_int;
    assign o_res_status = r_out_status;

    assign o_sts.clr_last  = (r_clr == BKT_W'(MAX_BUCKETS - 1));
    assign o_sts.mod_done  = w_mod_done;
    assign o_sts.head_zero = (r_head_q == '0);
    assign o_sts.hit       = (r_key_q == r_key);
    assign o_sts.link_zero = (r_lnk_q == '0);
    assign o_sts.out_free  = w_out_free;

`ifndef NO_ASSERTIONS
    a_used_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= LINK_W'(POOL_ENTRIES))
        else $error("pool count beyond pool size");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> w_out_free)
        else $error("result register overwritten");

    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_take |-> (r_link != '0))
        else $error("hit on empty link");
`endif

endmodule

`default_nettype wire

FILE: sv/chs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module chs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output chs_pkg::t_dp_cmd       o_cmd,
    input  wire chs_pkg::t_dp_sts  i_sts
);

    chs_pkg::t_state r_state;
    chs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chs_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            chs_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = chs_pkg::S_IDLE;
                end
            end
            chs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = chs_pkg::S_MOD;
                end
            end
            chs_pkg::S_MOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.head_rd = 1'b1;
                    n_state       = chs_pkg::S_HEAD;
                end
            end
            chs_pkg::S_HEAD: begin
                if (i_sts.head_zero) begin
                    n_state = chs_pkg::S_UPD;
                end else begin
                    o_cmd.head_take = 1'b1;
                    n_state         = chs_pkg::S_CMP;
                end
            end
            chs_pkg::S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.hit_take = 1'b1;
                    n_state        = chs_pkg::S_UPD;
                end else if (i_sts.link_zero) begin
                    n_state = chs_pkg::S_UPD;
                end else begin
                    o_cmd.ent_next = 1'b1;
                end
            end
            chs_pkg::S_UPD: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = chs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = chs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/chained_hash_table_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Key-value store built as a hash table with separately chained buckets over a
// bump-allocated entry pool. After reset the block clears its bucket heads, one
// per cycle, all MAX_BUCKETS of them, before it takes the first word. For a
// request, the remainder unit retires 8 key bits per cycle, and the chain walk
// reads one entry per cycle from the entry memories. One request is in flight
// at a time, and a finished result waits in an output register while the next
// word is taken.

module chained_hash_table_store #(
    parameter int MAX_BUCKETS  = 256,
    parameter int POOL_ENTRIES = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // key, ptr_value, int_value
    input  wire logic [chs_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // cmd
    input  wire logic [chs_pkg::CMD_W-1:0]           i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // found, ptr_out, int_out, status
    output logic [chs_pkg::OUT_TDATA_W-1:0]          o_m_axis_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [chs_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int PAD_W = chs_pkg::OUT_TDATA_W - chs_pkg::OUT_USED_W;

    chs_pkg::t_dp_cmd             w_cmd;
    chs_pkg::t_dp_sts             w_sts;
    logic                         w_found;
    logic [chs_pkg::PTR_W-1:0]    w_ptr;
    logic [chs_pkg::INT_W-1:0]    w_int;
    logic                         w_status;

    assign o_cfg_ready = 1'b1;

    chs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    chs_datapath #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_req_cmd    (i_s_axis_tuser),
        .i_req_key    (i_s_axis_tdata[63:0]),
        .i_req_ptr    (i_s_axis_tdata[127:64]),
        .i_req_int    (i_s_axis_tdata[159:128]),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res_found  (w_found),
        .o_res_ptr    (w_ptr),
        .o_res_int    (w_int),
        .o_res_status (w_status)
    );

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, w_status, w_int, w_ptr, w_found};

endmodule

`default_nettype wire
